@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ design/ncc_pkg.sv @@
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared constants and beat/token types of the nearest centroid classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ncc_pkg;

	localparam int NUM_CLUSTERS_DEF = 5;
	localparam int MAX_DIMS_DEF     = 64;
	localparam int VALUE_WIDTH_DEF  = 16;

	localparam int IDX_W  = 3;   // cluster index
	localparam int DIM_W  = 6;   // dimension index field
	localparam int CNT_W  = 7;   // element counter and dims_in_use
	localparam int ACC_W  = 40;  // distance accumulator, unsigned Q40.0
	localparam int OUT_W  = 48;  // output tdata, byte padded
	localparam int ADDR_W = 3;   // APB address
	localparam int DATA_W = 32;  // APB data

	localparam logic [ACC_W-1:0] ACC_MAX    = '1;
	localparam logic [CNT_W-1:0] CNT_MAX    = '1;
	localparam logic [CNT_W-1:0] DIMS_RESET = 7'd50;

	// register word index (paddr above the byte offset)
	localparam logic [ADDR_W-3:0] REG_DIMS = '0;

	// tuser action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_FEATURE = 1'b1;

	// control part of a beat travelling down the cell row
	typedef struct packed {
		logic             valid;
		logic             feat;   // feature element, else centroid load
		logic             last;   // final feature element of a vector
		logic             use_;   // feature: accumulate; load: dimension in range
		logic [IDX_W-1:0] csel;
	} ctl_t;

	// running minimum handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic [ACC_W-1:0] dmin;
	} tok_t;

endpackage

@@ design/ncc_ram.sv @@
// ----------------------------------------------------------------------------
// ncc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/ncc_cell.sv @@
// ----------------------------------------------------------------------------
// ncc_cell
// One centroid cell: holds one centroid and its distance accumulator,
// forwards each beat and the running minimum to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncc_cell #(
	parameter int IDX         = 0,
	parameter int MAX_DIMS    = 64,
	parameter int VALUE_WIDTH = 16,
	localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  ncc_pkg::ctl_t           ctl_in,
	input  logic [AW-1:0]           addr_in,
	input  logic [VALUE_WIDTH-1:0]  val_in,
	input  ncc_pkg::tok_t           tok_in,
	output ncc_pkg::ctl_t           ctl_out,
	output logic [AW-1:0]           addr_out,
	output logic [VALUE_WIDTH-1:0]  val_out,
	output ncc_pkg::tok_t           tok_out
);

	import ncc_pkg::*;

	localparam int DW    = VALUE_WIDTH + 1;
	localparam int SQ_W  = 2 * DW;
	localparam int SUM_W = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;
	localparam logic [IDX_W-1:0] CELL_ID = IDX_W'(IDX);

	ctl_t                    ctl_s1, ctl_s2, ctl_s3;
	logic [AW-1:0]           addr_s1;
	logic [VALUE_WIDTH-1:0]  val_s1, val_s2;
	logic [VALUE_WIDTH-1:0]  cent;
	logic [SQ_W-1:0]         sq_s3;
	logic [ACC_W-1:0]        acc_q;
	tok_t                    tok_q;

	logic                    we, re;
	logic signed [DW-1:0]    diff;
	logic [DW-1:0]           mag;
	logic [SUM_W-1:0]        sum;
	logic [ACC_W-1:0]        new_acc, own;
	logic                    take_own;

	// stage 1: beat arrives, centroid store written or read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1 <= addr_in;
			val_s1  <= val_in;
		end
	end

	assign we = en && ctl_s1.valid && !ctl_s1.feat && ctl_s1.use_ && (ctl_s1.csel == CELL_ID);
	assign re = en && ctl_s1.valid && ctl_s1.feat && ctl_s1.use_;

	ncc_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (MAX_DIMS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (val_s1),
		.re    (re),
		.raddr (addr_s1),
		.rdata (cent)
	);

	// stage 2: difference and square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign diff = $signed({val_s2[VALUE_WIDTH-1], val_s2}) - $signed({cent[VALUE_WIDTH-1], cent});
	assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

	always_ff @(posedge clk) begin
		if (en) begin
			val_s2 <= val_s1;
			sq_s3  <= SQ_W'(mag) * SQ_W'(mag);
		end
	end

	// stage 3: saturating accumulate, fold into the running minimum
	assign sum      = SUM_W'(acc_q) + SUM_W'(sq_s3);
	assign new_acc  = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
	assign own      = ctl_s3.use_ ? new_acc : acc_q;
	assign take_own = !tok_in.valid || (own < tok_in.dmin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			tok_q <= '0;
		end else if (en) begin
			if (ctl_s3.valid && ctl_s3.feat) begin
				if (ctl_s3.last) begin
					acc_q <= '0;
				end else if (ctl_s3.use_) begin
					acc_q <= new_acc;
				end
			end
			tok_q.valid <= ctl_s3.valid && ctl_s3.feat && ctl_s3.last;
			tok_q.idx   <= take_own ? CELL_ID : tok_in.idx;
			tok_q.dmin  <= take_own ? own : tok_in.dmin;
		end
	end

	assign ctl_out  = ctl_s1;
	assign addr_out = addr_s1;
	assign val_out  = val_s1;
	assign tok_out  = tok_q;

endmodule

@@ design/nearest_centroid_classifier.sv @@
// ----------------------------------------------------------------------------
// nearest_centroid_classifier
// Nearest centroid assignment (k-means assignment step) on a row of cells.
//
//  channel  dir  beat contents
//  -------  ---  ----------------------------------------------------------
//  s_axis   in   tuser: action; tdata: cluster_sel, dim_index, value; tlast
//  m_axis   out  tdata: best_cluster, best_distance
//  apb      in   register dims_in_use at byte address 0
//
//  One input beat per cycle while s_tready is high, loads and features alike;
//  each cell's store port and squarer take one beat per cycle unless stalled.
//  After the last feature beat, each cell runs it through its three stages
//  and the running minimum walks the row cell by cell to the output register.
//  Reset clears accumulators, counter and handshake state; no store clear.
//  s_tready drops only while a result sits at the row end and the output
//  register holds an untaken result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_centroid_classifier #(
	parameter int NUM_CLUSTERS = ncc_pkg::NUM_CLUSTERS_DEF,
	parameter int MAX_DIMS     = ncc_pkg::MAX_DIMS_DEF,
	parameter int VALUE_WIDTH  = ncc_pkg::VALUE_WIDTH_DEF,
	localparam int IN_W = ((ncc_pkg::IDX_W + ncc_pkg::DIM_W + VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ncc_pkg::ADDR_W-1:0]    paddr,
	input  logic [ncc_pkg::DATA_W-1:0]    pwdata,
	output logic [ncc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,  // cluster_sel, dim_index, value, zero pad
	input  logic [0:0]                    s_tuser,  // action
	input  logic                          s_tlast,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ncc_pkg::OUT_W-1:0]     m_tdata   // best_cluster, best_distance, zero pad
);

	import ncc_pkg::*;

	localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int PAD_IN  = IN_W - IDX_W - DIM_W - VALUE_WIDTH;
	localparam int PAD_OUT = OUT_W - IDX_W - ACC_W;

	logic [CNT_W-1:0]        dims_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        limit;
	logic                    accept, feat, en;
	logic [IDX_W-1:0]        in_csel;
	logic [DIM_W-1:0]        in_dim;
	logic [VALUE_WIDTH-1:0]  in_val;
	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic [ACC_W-1:0]        out_dist_q;

	ctl_t                    ctl_w  [NUM_CLUSTERS+1];
	logic [AW-1:0]           addr_w [NUM_CLUSTERS+1];
	logic [VALUE_WIDTH-1:0]  val_w  [NUM_CLUSTERS+1];
	tok_t                    tok_w  [NUM_CLUSTERS+1];
	tok_t                    res;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_DIMS) ? DATA_W'(dims_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_DIMS)) begin
			dims_q <= pwdata[CNT_W-1:0];
		end
	end

	assign limit = (dims_q > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : dims_q;

	// input beat
	assign in_csel = s_tdata[IDX_W-1:0];
	assign in_dim  = s_tdata[IDX_W +: DIM_W];
	assign in_val  = s_tdata[IDX_W+DIM_W +: VALUE_WIDTH];
	assign feat    = (s_tuser[0] == ACT_FEATURE);

	assign res      = tok_w[NUM_CLUSTERS];
	assign en       = !(res.valid && out_valid_q && !m_tready);
	assign s_tready = en;
	assign accept   = s_tvalid && s_tready;

	assign ctl_w[0].valid = accept;
	assign ctl_w[0].feat  = feat;
	assign ctl_w[0].last  = feat && s_tlast;
	assign ctl_w[0].use_  = feat ? (cnt_q < limit) : (CNT_W'(in_dim) < CNT_W'(MAX_DIMS));
	assign ctl_w[0].csel  = in_csel;
	assign addr_w[0]      = feat ? cnt_q[AW-1:0] : in_dim[AW-1:0];
	assign val_w[0]       = in_val;
	assign tok_w[0]       = '0;

	// element counter: saturate, clear after the last element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && feat) begin
			if (s_tlast) begin
				cnt_q <= '0;
			end else if (cnt_q != CNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// cell row
	for (genvar k = 0; k < NUM_CLUSTERS; k++) begin : g_cell
		ncc_cell #(
			.IDX         (k),
			.MAX_DIMS    (MAX_DIMS),
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_in   (ctl_w[k]),
			.addr_in  (addr_w[k]),
			.val_in   (val_w[k]),
			.tok_in   (tok_w[k]),
			.ctl_out  (ctl_w[k+1]),
			.addr_out (addr_w[k+1]),
			.val_out  (val_w[k+1]),
			.tok_out  (tok_w[k+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res.valid) begin
			out_idx_q  <= res.idx;
			out_dist_q <= res.dmin;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_OUT'(0), out_dist_q, out_idx_q};

	// the tail of the row reads nothing else; keep the pad bits visible
	logic unused_pad;
	assign unused_pad = ^{ctl_w[NUM_CLUSTERS], addr_w[NUM_CLUSTERS], val_w[NUM_CLUSTERS],
		s_tdata[IN_W-1 -: PAD_IN]};

	`ASSERT_IMPL(a_stall_only_when_blocked, !s_tready, m_tvalid && !m_tready)
	`ASSERT_NEXT(a_cnt_clear_on_last, accept && feat && s_tlast, cnt_q == '0)
	`ASSERT_NEXT(a_cnt_saturates, accept && feat && !s_tlast && (cnt_q == CNT_MAX),
		cnt_q == CNT_MAX)

endmodule
